@@ hw/rtl/usb_byte_stream_to_can_fd_frame_macros.svh @@
// Assertion macros used by the top level of the host-to-CAN-FD frame parser.
`ifndef USB_BYTE_STREAM_TO_CAN_FD_FRAME_MACROS_SVH
`define USB_BYTE_STREAM_TO_CAN_FD_FRAME_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define USBCANFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define USBCANFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/usbcanfd_pkg.sv @@
// Types, codes and the length-code table of the host-to-CAN-FD frame parser.
package usbcanfd_pkg;

  // Largest payload of one frame.
  localparam int unsigned MaxPayloadDef = 64;
  // Entries of the job queue between parser and frame sender.
  localparam int unsigned JobDepthDef = 2;
  // Width of lengths and byte counters (holds 0 to 127).
  localparam int unsigned LenW = 7;
  // Default inter-byte timeout in ticks.
  localparam logic [15:0] TimeoutReset = 16'd10;
  // Footer byte that closes a packet.
  localparam logic [7:0] FooterByte = 8'hBB;
  // Largest standard identifier.
  localparam logic [31:0] StdIdMax = 32'h0000_07FF;
  // Longest classic CAN payload.
  localparam logic [LenW-1:0] ClassicMax = 7'd8;

  // Input beat kinds carried on tuser.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Outcome of one packet.
  typedef enum logic [1:0] {
    ST_SENT    = 2'd0,
    ST_FOOTER  = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_CHANNEL = 2'd3
  } status_e;

  // One finished packet handed from the parser to the sender.
  typedef struct packed {
    status_e         status;
    logic            channel;
    logic [31:0]     can_id;
    logic [LenW-1:0] length;
    logic            bank;
  } job_t;

  // Payload bank given back by the sender when its frame is out.
  typedef struct packed {
    logic done;
    logic bank;
  } release_t;

  // CAN FD length code and the length it stands for.
  typedef struct packed {
    logic [3:0]      code;
    logic [LenW-1:0] coded;
  } dlc_t;

  // Round a payload length up to the next CAN FD length.
  function automatic dlc_t dlc_of(logic [LenW-1:0] len);
    dlc_t r;
    if (len <= 7'd8) begin
      r.code  = len[3:0];
      r.coded = len;
    end else if (len <= 7'd12) begin
      r.code = 4'd9;  r.coded = 7'd12;
    end else if (len <= 7'd16) begin
      r.code = 4'd10; r.coded = 7'd16;
    end else if (len <= 7'd20) begin
      r.code = 4'd11; r.coded = 7'd20;
    end else if (len <= 7'd24) begin
      r.code = 4'd12; r.coded = 7'd24;
    end else if (len <= 7'd32) begin
      r.code = 4'd13; r.coded = 7'd32;
    end else if (len <= 7'd48) begin
      r.code = 4'd14; r.coded = 7'd48;
    end else begin
      r.code = 4'd15; r.coded = 7'd64;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/usb_byte_stream_to_can_fd_frame.sv @@
// Top level of the host byte stream to CAN FD transmit frame parser.
//
// A start beat arms the parser; data beats then carry the channel byte, four
// identifier bytes (least significant first), a length byte capped at
// MaxPayload, the payload and a 0xBB footer, and tick beats count toward the
// inter-byte timeout set through the configuration channel (reset value 10).
// A good packet comes out as one beat per byte of its CAN FD coded length
// (one beat for an empty frame), zero padded past the received length; a bad
// footer, a timeout or an unknown channel comes out as a single status beat.
// The parser takes one input beat per cycle. It holds tready low while the
// two-entry job queue is full, or while it is in the payload or footer phase
// and the payload RAM bank it writes still holds a frame being sent; the RAM
// has two banks, so one frame can be sent while the next is received. The
// sender fetches a job, then for each output beat reads one byte from the RAM
// and presents it, holding it until the sink takes it; a status beat skips the
// read. No clearing pass after reset.
`include "usb_byte_stream_to_can_fd_frame_macros.svh"

module usb_byte_stream_to_can_fd_frame #(
  parameter int unsigned MaxPayload = usbcanfd_pkg::MaxPayloadDef,
  parameter int unsigned JobDepth   = usbcanfd_pkg::JobDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Timeout register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Host beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // Result beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] channel, [32:1] can_id, [33] extended_id, [37:34] dlc_code,
  // [38] fd_format, [39] bit_rate_switch, [47:40] payload_byte
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] byte_valid
  output logic        m_axis_tlast
);
  import usbcanfd_pkg::*;

  localparam int unsigned RamAddrW = $clog2(MaxPayload) + 1;
  localparam int unsigned RamDepth = 2 ** RamAddrW;

  logic                job_push;
  job_t                job_in;
  logic                job_full;
  logic                job_pop;
  job_t                job_out;
  logic                job_empty;
  release_t            rel;
  logic                ram_we;
  logic [RamAddrW-1:0] ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [RamAddrW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;

  // The register may be written at any cycle.
  assign cfg_ready_o = 1'b1;

  usbcanfd_front #(
    .MaxPayload (MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full),
    .rel_i       (rel),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  usbcanfd_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  usbcanfd_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  usbcanfd_back #(
    .MaxPayload (MaxPayload)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .rel_o       (rel),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // A job is never offered to a full queue.
  `USBCANFD_ASSERT_NOW(a_no_job_overflow, job_push, !job_full, "job pushed into full queue")

  // A status beat is a single beat with no payload.
  `USBCANFD_ASSERT_NOW(a_status_single, m_axis_tvalid && (m_axis_tuser[1:0] != ST_SENT), m_axis_tlast && !m_axis_tuser[2], "status beat not single")

  // After the last beat of a run the sender goes back for a new job.
  `USBCANFD_ASSERT_NEXT(a_gap_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "beat right after last")

  // Parser and sender never use the same payload bank at once.
  `USBCANFD_ASSERT_NOW(a_bank_apart, ram_we && ram_re, ram_waddr[RamAddrW-1] != ram_raddr[RamAddrW-1], "bank shared by parser and sender")

endmodule

@@ hw/rtl/usbcanfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module usbcanfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data valid the cycle after the enable.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hw/rtl/usbcanfd_front.sv @@
// Packet parser: takes host beats, fills a payload bank and queues outcomes.
module usbcanfd_front #(
  parameter int unsigned MaxPayload = usbcanfd_pkg::MaxPayloadDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Host beats.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      in_action_i,
  input  logic [7:0]                      in_byte_i,
  // Timeout register write.
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_data_i,
  // Job queue push side.
  output logic                            job_push_o,
  output usbcanfd_pkg::job_t              job_o,
  input  logic                            job_full_i,
  // Bank release from the sender.
  input  usbcanfd_pkg::release_t          rel_i,
  // Payload RAM write port.
  output logic                            ram_we_o,
  output logic [$clog2(MaxPayload):0]     ram_waddr_o,
  output logic [7:0]                      ram_wdata_o
);
  import usbcanfd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPayload);
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPayload);

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHAN,
    F_ID,
    F_LEN,
    F_DATA,
    F_FOOT
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            chan_bit_q, chan_bit_d;
  logic            chan_bad_q, chan_bad_d;
  logic [31:0]     id_q, id_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [15:0]     idle_q, idle_d;
  logic [15:0]     timeout_q, timeout_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;

  action_e         action;
  logic            accept;
  logic [15:0]     idle_inc;
  logic [LenW-1:0] cnt_inc;

  assign action   = action_e'(in_action_i);
  assign accept   = in_valid_i && in_ready_o;
  assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign cnt_inc  = cnt_q + 7'd1;

  // Hold input while the queue is full or the bank in use is still being sent.
  assign in_ready_o = !job_full_i &&
                      !(((phase_q == F_DATA) || (phase_q == F_FOOT)) && busy_q[bank_q]);

  // Payload bytes go to the current bank at the running byte index.
  assign ram_we_o    = accept && (action == ACT_BYTE) && (phase_q == F_DATA);
  assign ram_waddr_o = {bank_q, cnt_q[IdxW-1:0]};
  assign ram_wdata_o = in_byte_i;

  // Parser next state and job generation.
  always_comb begin
    phase_d    = phase_q;
    chan_bit_d = chan_bit_q;
    chan_bad_d = chan_bad_q;
    id_d       = id_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    idle_d     = idle_q;
    timeout_d  = cfg_we_i ? cfg_data_i : timeout_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    job_push_o = 1'b0;
    job_o      = '0;

    if (rel_i.done) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept) begin
      if (action == ACT_START) begin
        phase_d = F_CHAN;
        cnt_d   = '0;
        idle_d  = '0;
        id_d    = '0;
        len_d   = '0;
      end else if ((phase_q != F_IDLE) && (action == ACT_TICK)) begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_q) begin
          job_push_o  = 1'b1;
          job_o.status = ST_TIMEOUT;
          phase_d     = F_IDLE;
        end
      end else if ((phase_q != F_IDLE) && (action == ACT_BYTE)) begin
        idle_d = '0;
        unique case (phase_q)
          F_CHAN: begin
            chan_bit_d = in_byte_i[0];
            chan_bad_d = (in_byte_i[7:1] != 7'd0);
            cnt_d      = '0;
            id_d       = '0;
            phase_d    = F_ID;
          end
          F_ID: begin
            case (cnt_q[1:0])
              2'd0:    id_d[7:0]   = in_byte_i;
              2'd1:    id_d[15:8]  = in_byte_i;
              2'd2:    id_d[23:16] = in_byte_i;
              default: id_d[31:24] = in_byte_i;
            endcase
            cnt_d = cnt_inc;
            if (cnt_q[1:0] == 2'd3) begin
              cnt_d   = '0;
              phase_d = F_LEN;
            end
          end
          F_LEN: begin
            len_d   = ({1'b0, in_byte_i} > {1'b0, 1'b0, MaxLen}) ? MaxLen
                                                                 : in_byte_i[LenW-1:0];
            cnt_d   = '0;
            phase_d = (len_d == '0) ? F_FOOT : F_DATA;
          end
          F_DATA: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= len_q) begin
              phase_d = F_FOOT;
            end
          end
          F_FOOT: begin
            job_push_o = 1'b1;
            phase_d    = F_IDLE;
            if (in_byte_i != FooterByte) begin
              job_o.status = ST_FOOTER;
            end else if (chan_bad_q) begin
              job_o.status = ST_CHANNEL;
            end else begin
              job_o.status  = ST_SENT;
              job_o.channel = chan_bit_q;
              job_o.can_id  = id_q;
              job_o.length  = len_q;
              job_o.bank    = bank_q;
              busy_d[bank_q] = 1'b1;
              bank_d         = !bank_q;
            end
          end
          default: phase_d = F_IDLE;
        endcase
      end
    end
  end

  // Parser state, counters and bank ownership.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= F_IDLE;
      chan_bit_q <= 1'b0;
      chan_bad_q <= 1'b0;
      id_q       <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      idle_q     <= '0;
      timeout_q  <= TimeoutReset;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      chan_bit_q <= chan_bit_d;
      chan_bad_q <= chan_bad_d;
      id_q       <= id_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      idle_q     <= idle_d;
      timeout_q  <= timeout_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

endmodule

@@ hw/rtl/usbcanfd_job_fifo.sv @@
// Short queue of finished packets between parser and frame sender.
module usbcanfd_job_fifo #(
  parameter int unsigned Depth = usbcanfd_pkg::JobDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  usbcanfd_pkg::job_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output usbcanfd_pkg::job_t data_o,
  output logic               empty_o
);
  import usbcanfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW:0] DepthVal = (PtrW + 1)'(Depth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            slot_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == DepthVal);
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rptr_q];

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/usbcanfd_back.sv @@
// Frame sender: turns queued packets into output beats, reading the payload RAM.
module usbcanfd_back #(
  parameter int unsigned MaxPayload = usbcanfd_pkg::MaxPayloadDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Job queue pop side.
  input  usbcanfd_pkg::job_t              job_i,
  input  logic                            job_empty_i,
  output logic                            job_pop_o,
  // Bank release to the parser.
  output usbcanfd_pkg::release_t          rel_o,
  // Payload RAM read port.
  output logic                            ram_re_o,
  output logic [$clog2(MaxPayload):0]     ram_raddr_o,
  input  logic [7:0]                      ram_rdata_i,
  // Result beats.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [47:0]                     out_data_o,
  output logic [2:0]                      out_user_o,
  output logic                            out_last_o
);
  import usbcanfd_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPayload);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } b_state_e;

  b_state_e        state_q;
  job_t            job_q;
  logic [LenW-1:0] k_q;

  dlc_t            dlc;
  logic [LenW-1:0] n_last;
  logic            big;
  logic            byte_ok;
  logic            beat_last;
  logic            take;

  assign dlc       = dlc_of(job_q.length);
  assign n_last    = (dlc.coded == '0) ? '0 : dlc.coded - 7'd1;
  assign big       = (job_q.length > ClassicMax);
  assign byte_ok   = (k_q < job_q.length);
  assign beat_last = (k_q == n_last);
  assign take      = (state_q == B_SHOW) && out_ready_i;

  assign job_pop_o   = (state_q == B_IDLE) && !job_empty_i;
  assign ram_re_o    = (state_q == B_READ);
  assign ram_raddr_o = {job_q.bank, k_q[IdxW-1:0]};

  // Give the bank back once the last beat of a sent frame is taken.
  assign rel_o.done = take && beat_last && (job_q.status == ST_SENT);
  assign rel_o.bank = job_q.bank;

  // Result beat fields.
  always_comb begin
    out_valid_o       = (state_q == B_SHOW);
    out_last_o        = beat_last;
    out_user_o[1:0]   = job_q.status;
    out_user_o[2]     = (dlc.coded != '0);
    out_data_o[0]     = job_q.channel;
    out_data_o[32:1]  = job_q.can_id;
    out_data_o[33]    = (job_q.can_id > StdIdMax);
    out_data_o[37:34] = dlc.code;
    out_data_o[38]    = big;
    out_data_o[39]    = big;
    out_data_o[47:40] = byte_ok ? ram_rdata_i : 8'd0;
  end

  // Sender sequence: fetch a job, then read and present one byte at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      job_q   <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            k_q     <= '0;
            state_q <= (job_i.status == ST_SENT) ? B_READ : B_SHOW;
          end
        end
        B_READ: begin
          state_q <= B_SHOW;
        end
        B_SHOW: begin
          if (out_ready_i) begin
            if (beat_last) begin
              state_q <= B_IDLE;
            end else begin
              k_q     <= k_q + 7'd1;
              state_q <= B_READ;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the host byte stream to CAN FD transmit frame parser.
module testbench;
  import usbcanfd_pkg::*;

  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned TailCycles   = 160;
  localparam int          PhaseItems   = 20;

  // Parse position of the host packet, mirrored in the bench.
  typedef enum logic [2:0] {
    HOST_IDLE,
    HOST_CHAN,
    HOST_ID,
    HOST_LEN,
    HOST_DATA,
    HOST_FOOT
  } host_phase_e;

  // One result beat, field by field.
  typedef struct packed {
    status_e     status;
    logic        channel;
    logic [31:0] can_id;
    logic        extended;
    logic [3:0]  dlc;
    logic        fd;
    logic        brs;
    logic [7:0]  payload;
    logic        byte_valid;
    logic        last;
  } frame_beat_t;

  // One row of the directed stimulus table.
  typedef struct packed {
    action_e     act;
    logic [7:0]  data;
    logic        pinned;
    frame_beat_t beat;
  } host_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] channel, [32:1] can_id, [33] extended_id, [37:34] dlc_code,
  // [38] fd_format, [39] bit_rate_switch, [47:40] payload_byte
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // [1:0] status, [2] byte_valid
  logic        m_axis_tlast;

  // Bench copy of the parser state and the timeout register.
  host_phase_e host_phase;
  logic [7:0]  chan_q;
  logic [31:0] id_q;
  logic [6:0]  len_q;
  logic [6:0]  count_q;
  logic [7:0]  payload_q [64];
  logic [15:0] idle_q;
  logic [15:0] timeout_q;

  frame_beat_t expected_beats [$];
  host_row_t   host_rows [$];
  int          fail_count = 0;
  int          live_items = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en;
  bit          hold_req;
  bit          pin_now;
  frame_beat_t pin_beat;

  always #2 clk_i = ~clk_i;

  usb_byte_stream_to_can_fd_frame dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic frame_beat_t mk_beat(status_e st, logic ch, logic [31:0] id,
                                          logic ext, logic [3:0] dlc, logic fd,
                                          logic brs, logic [7:0] pay, logic vld,
                                          logic lst);
    frame_beat_t r;
    r.status     = st;
    r.channel    = ch;
    r.can_id     = id;
    r.extended   = ext;
    r.dlc        = dlc;
    r.fd         = fd;
    r.brs        = brs;
    r.payload    = pay;
    r.byte_valid = vld;
    r.last       = lst;
    return r;
  endfunction

  // Advances the parser copy by one host beat and queues the frame beats it
  // causes. Returns the number queued, or -1 when the beat is ignored.
  function automatic int predict_beat(action_e act, logic [7:0] b);
    logic       big;
    logic [3:0] code;
    logic [6:0] coded;
    int         n;
    int         k;
    if (act == ACT_START) begin
      host_phase = HOST_CHAN;
      count_q    = '0;
      idle_q     = '0;
      id_q       = '0;
      len_q      = '0;
      return 0;
    end
    if (host_phase == HOST_IDLE || act == ACT_NONE) return -1;

    // Ticks saturate and abandon the packet once they reach the timeout.
    if (act == ACT_TICK) begin
      if (idle_q != 16'hFFFF) idle_q++;
      if (idle_q >= timeout_q) begin
        host_phase = HOST_IDLE;
        expected_beats.push_back(mk_beat(ST_TIMEOUT, '0, '0, '0, '0, '0, '0, '0, '0,
                                         1'b1));
        return 1;
      end
      return 0;
    end

    idle_q = '0;
    case (host_phase)
      HOST_CHAN: begin
        chan_q     = b;
        count_q    = '0;
        id_q       = '0;
        host_phase = HOST_ID;
      end
      HOST_ID: begin
        id_q = id_q | (32'(b) << (8 * count_q[1:0]));
        count_q++;
        if (count_q >= 7'd4) begin
          count_q    = '0;
          host_phase = HOST_LEN;
        end
      end
      HOST_LEN: begin
        len_q      = (b > 8'(MaxPayloadDef)) ? 7'(MaxPayloadDef) : b[6:0];
        count_q    = '0;
        host_phase = (len_q == '0) ? HOST_FOOT : HOST_DATA;
      end
      HOST_DATA: begin
        if (count_q < 7'(MaxPayloadDef)) payload_q[count_q[5:0]] = b;
        count_q++;
        if (count_q >= len_q) host_phase = HOST_FOOT;
      end
      HOST_FOOT: begin
        host_phase = HOST_IDLE;
        // A bad footer wins over a bad channel.
        if (b != FooterByte) begin
          expected_beats.push_back(mk_beat(ST_FOOTER, '0, '0, '0, '0, '0, '0, '0, '0,
                                           1'b1));
          return 1;
        end
        if (chan_q > 8'd1) begin
          expected_beats.push_back(mk_beat(ST_CHANNEL, '0, '0, '0, '0, '0, '0, '0, '0,
                                           1'b1));
          return 1;
        end
        // Round the length up to the next CAN FD length and pad with zeros.
        big = (len_q > ClassicMax);
        if (len_q <= 7'd8) begin
          code  = len_q[3:0];
          coded = len_q;
        end else if (len_q <= 7'd12) begin
          code = 4'd9;  coded = 7'd12;
        end else if (len_q <= 7'd16) begin
          code = 4'd10; coded = 7'd16;
        end else if (len_q <= 7'd20) begin
          code = 4'd11; coded = 7'd20;
        end else if (len_q <= 7'd24) begin
          code = 4'd12; coded = 7'd24;
        end else if (len_q <= 7'd32) begin
          code = 4'd13; coded = 7'd32;
        end else if (len_q <= 7'd48) begin
          code = 4'd14; coded = 7'd48;
        end else begin
          code = 4'd15; coded = 7'd64;
        end
        // An empty frame still gives one beat, marked as carrying no byte.
        n = (coded == '0) ? 1 : int'(coded);
        for (k = 0; k < n; k++) begin
          expected_beats.push_back(mk_beat(ST_SENT, chan_q[0], id_q, id_q > StdIdMax,
                                           code, big, big,
                                           (k < int'(len_q)) ? payload_q[k] : 8'h00,
                                           coded != '0, k == n - 1));
        end
        return n;
      end
      default: host_phase = HOST_IDLE;
    endcase
    return 0;
  endfunction

  // Checks result beats against the oldest expectation and predicts from host beats.
  always @(posedge clk_i) begin : monitor
    frame_beat_t got;
    frame_beat_t want;
    int          n;
    int          k;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) timeout_q = cfg_data_i;

      if (m_axis_tvalid && m_axis_tready) begin
        got = mk_beat(status_e'(m_axis_tuser[1:0]), m_axis_tdata[0], m_axis_tdata[32:1],
                      m_axis_tdata[33], m_axis_tdata[37:34], m_axis_tdata[38],
                      m_axis_tdata[39], m_axis_tdata[47:40], m_axis_tuser[2],
                      m_axis_tlast);
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count += 1;
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count += 1;
          end
          if (got.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, got.channel);
            fail_count += 1;
          end
          if (got.can_id !== want.can_id) begin
            $error("can_id: expected %08h, got %08h", want.can_id, got.can_id);
            fail_count += 1;
          end
          if (got.extended !== want.extended) begin
            $error("extended_id: expected %0d, got %0d", want.extended, got.extended);
            fail_count += 1;
          end
          if (got.dlc !== want.dlc) begin
            $error("dlc_code: expected %0d, got %0d", want.dlc, got.dlc);
            fail_count += 1;
          end
          if (got.fd !== want.fd) begin
            $error("fd_format: expected %0d, got %0d", want.fd, got.fd);
            fail_count += 1;
          end
          if (got.brs !== want.brs) begin
            $error("bit_rate_switch: expected %0d, got %0d", want.brs, got.brs);
            fail_count += 1;
          end
          if (got.payload !== want.payload) begin
            $error("payload_byte: expected %02h, got %02h", want.payload, got.payload);
            fail_count += 1;
          end
          if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
            fail_count += 1;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count += 1;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        n = predict_beat(action_e'(s_axis_tuser), s_axis_tdata);
        if (n >= 0) live_items++;
        // Table rows with a typed result replace what the predictor queued.
        if (pin_now) begin
          for (k = 0; k < n; k++) void'(expected_beats.pop_back());
          expected_beats.push_back(pin_beat);
        end
      end
    end
  end

  // Counts cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("usb_byte_stream_to_can_fd_frame: mismatch");
    $finish;
  end

  // Result sink: random back-pressure bursts and one long hold-off on request.
  initial begin : sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one host beat, called and returning at a falling edge.
  task automatic send(action_e act, logic [7:0] b);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // A data byte, sometimes preceded by ticks; some runs of ticks reach the timeout.
  task automatic send_host_byte(logic [7:0] b);
    int r;
    int ticks;
    r     = $urandom_range(0, 99);
    ticks = 0;
    if (r < 12 && timeout_q > 16'd1) begin
      ticks = $urandom_range(1, (timeout_q > 16'd5) ? 4 : int'(timeout_q) - 1);
    end else if (r < 15 && timeout_q <= 16'd24) begin
      ticks = int'(timeout_q);
    end
    repeat (ticks) send(ACT_TICK, 8'($urandom_range(0, 255)));
    send(ACT_BYTE, b);
  endtask

  // One random packet; unless clean, it may be noise or cut short.
  task automatic gen_packet(bit clean);
    int          r;
    int          pick;
    int          len;
    int          n;
    int          total;
    int          stop;
    int          k;
    logic [31:0] id;
    logic [7:0]  pkt [0:70];
    r = $urandom_range(0, 99);
    if (!clean && r < 12) begin
      repeat ($urandom_range(1, 4)) begin
        send(action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      return;
    end
    pkt[0] = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 1))
                                        : 8'($urandom_range(2, 255));
    case ($urandom_range(0, 3))
      0:       id = $urandom_range(0, 32'h7FF);
      1:       id = ($urandom_range(0, 1) == 0) ? 32'h7FF : 32'h800;
      default: id = $urandom;
    endcase
    pkt[1] = id[7:0];
    pkt[2] = id[15:8];
    pkt[3] = id[23:16];
    pkt[4] = id[31:24];
    // Mostly short lengths, a few long ones and a few that saturate.
    pick = $urandom_range(0, 99);
    if (pick < 55)      len = $urandom_range(0, 8);
    else if (pick < 85) len = $urandom_range(9, 24);
    else if (pick < 95) len = $urandom_range(25, 64);
    else                len = $urandom_range(65, 255);
    pkt[5] = 8'(len);
    n = (len > int'(MaxPayloadDef)) ? int'(MaxPayloadDef) : len;
    for (k = 0; k < n; k++) pkt[6 + k] = 8'($urandom_range(0, 255));
    pkt[6 + n] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : FooterByte;
    total = 7 + n;
    stop  = (!clean && r < 24) ? $urandom_range(0, total - 1) : total;
    send(ACT_START, 8'($urandom_range(0, 255)));
    for (k = 0; k < stop; k++) send_host_byte(pkt[k]);
  endtask

  task automatic run_phase(int target);
    int start;
    start = live_items;
    while (live_items - start < target) gen_packet(1'b0);
    gen_packet(1'b1);
  endtask

  // Stops offering and waits for every expected beat, then for some more cycles.
  task automatic drain(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_row(action_e act, logic [7:0] data, logic pinned,
                                  frame_beat_t beat);
    host_row_t row;
    row.act    = act;
    row.data   = data;
    row.pinned = pinned;
    row.beat   = beat;
    host_rows.push_back(row);
  endfunction

  initial begin : stimulus
    int i;
    int split;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_NONE;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    pin_now       = 1'b0;
    pin_beat      = '0;
    host_phase    = HOST_IDLE;
    chan_q        = '0;
    id_q          = '0;
    len_q         = '0;
    count_q       = '0;
    idle_q        = '0;
    timeout_q     = TimeoutReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Beats with no packet open are ignored.
    add_row(ACT_TICK, 8'h00, 1'b0, '0);
    add_row(ACT_NONE, 8'hFF, 1'b0, '0);
    // Empty frame on channel 1 with the highest identifier.
    add_row(ACT_START, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, 8'h01, 1'b0, '0);
    repeat (4) add_row(ACT_BYTE, 8'hFF, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, FooterByte, 1'b1,
            mk_beat(ST_SENT, 1'b1, 32'hFFFF_FFFF, 1'b1, '0, '0, '0, 8'h00, '0, 1'b1));
    // Bad footer and bad channel together report the footer.
    add_row(ACT_START, 8'hFF, 1'b0, '0);
    add_row(ACT_BYTE, 8'h02, 1'b0, '0);
    repeat (4) add_row(ACT_BYTE, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 1'b1,
            mk_beat(ST_FOOTER, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    // From here the timeout is one tick.
    split = host_rows.size();
    add_row(ACT_START, 8'h00, 1'b0, '0);
    add_row(ACT_TICK, 8'h00, 1'b1,
            mk_beat(ST_TIMEOUT, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    // Unknown channel with a good footer and the largest standard identifier.
    add_row(ACT_START, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, 8'hFE, 1'b0, '0);
    add_row(ACT_BYTE, 8'hFF, 1'b0, '0);
    add_row(ACT_BYTE, 8'h07, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, 8'h00, 1'b0, '0);
    add_row(ACT_BYTE, FooterByte, 1'b1,
            mk_beat(ST_CHANNEL, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));

    for (i = 0; i < host_rows.size(); i++) begin
      if (i == split) begin
        drain(SettleCycles);
        write_timeout(16'd1);
      end
      pin_now  = host_rows[i].pinned;
      pin_beat = host_rows[i].beat;
      send(host_rows[i].act, host_rows[i].data);
    end
    pin_now = 1'b0;

    // Short timeout, with the sink holding off long enough to stall the input.
    drain(SettleCycles);
    write_timeout(16'd3);
    hold_req = 1'b1;
    run_phase(PhaseItems);

    // Largest timeout, with one pause until every result is out.
    drain(SettleCycles);
    write_timeout(16'hFFFF);
    run_phase(PhaseItems / 2);
    drain(1);
    run_phase(PhaseItems / 2);

    drain(SettleCycles);
    write_timeout(16'($urandom_range(2, 20)));
    run_phase(PhaseItems);

    // Final stretch at full rate on both sides.
    drain(SettleCycles);
    idle_en = 1'b0;
    write_timeout(16'($urandom_range(4, 12)));
    run_phase(PhaseItems);

    drain(TailCycles);
    if (fail_count == 0) begin
      $display("usb_byte_stream_to_can_fd_frame: match");
    end else begin
      $display("usb_byte_stream_to_can_fd_frame: mismatch");
    end
    $finish;
  end

endmodule

@@ usb_byte_stream_to_can_fd_frame.f @@
+incdir+hw/rtl
hw/rtl/usbcanfd_pkg.sv
hw/rtl/usbcanfd_ram.sv
hw/rtl/usbcanfd_front.sv
hw/rtl/usbcanfd_job_fifo.sv
hw/rtl/usbcanfd_back.sv
hw/rtl/usb_byte_stream_to_can_fd_frame.sv
bench/testbench.sv
